@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module.
// No dependencies; pulled in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low.
`define NSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nearest site search check failed");

// Same, for a plain implication written as two terms.
`define NSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    `NSS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

@@ rtl/core/nss_pkg.sv @@
// Package for the nearest site search block: sizes, command codes, helpers.
// No dependencies.
`timescale 1ns / 1ps

package nss_pkg;

    localparam int MAX_SITES = 16;
    localparam int IDX_W     = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int CNT_W     = $clog2(MAX_SITES + 1);
    localparam int OUT_IDX_W = 4;
    localparam int CMD_W     = 2;
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = SQ_W + 1;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [OUT_IDX_W-1:0] t_out_idx;
    typedef logic [DIST_W-1:0]    t_dist;

    localparam t_cmd CMD_CLEAR  = 2'd0;
    localparam t_cmd CMD_APPEND = 2'd1;
    localparam t_cmd CMD_QUERY  = 2'd2;

    // Low bits of a site number as shown on the result port.
    function automatic t_out_idx to_out_idx(t_cnt v);
        logic [CNT_W+OUT_IDX_W-1:0] w;
        w = {{OUT_IDX_W{1'b0}}, v};
        return w[OUT_IDX_W-1:0];
    endfunction

endpackage

@@ rtl/core/nearest_site_search.sv @@
// Nearest site search: site table plus a squared-distance scan over it.
// One shared squarer walks the stored sites under a small sequencer.
// Depends on nss_pkg.
//
//   channel   valid        ready        word
//   input     i_in_valid   o_in_ready   i_command, i_coord_x, i_coord_y
//   output    o_out_valid  i_out_ready  o_answered, o_found, o_nearest_index,
//                                       o_nearest_distance, o_table_full
//
// Clear, append, unused commands and empty-table queries go from S_IDLE to S_DONE;
// the result register loads in S_DONE once the output register is free.
// Query over n > 0 stored sites: after S_RD, each site uses the squarer
// twice (x then y) plus one add-and-compare step, reading the site memory once.
// Reset (synchronous, active low) empties the table; site memory is not cleared.
// New words are taken only in S_IDLE. A waiting result does not block accepting the next word; the sequencer only
// stalls at its last step until the output register is free.
`timescale 1ns / 1ps

module nearest_site_search (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  nss_pkg::t_cmd          i_command,
    input  logic signed [15:0]     i_coord_x,
    input  logic signed [15:0]     i_coord_y,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_answered,
    output logic                   o_found,
    output nss_pkg::t_out_idx      o_nearest_index,
    output nss_pkg::t_dist         o_nearest_distance,
    output logic                   o_table_full
);
    import nss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_SQX  = 3'd2;
    localparam logic [2:0] S_SQY  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]               r_state, n_state;
    t_cnt                     r_count, n_count;
    t_cnt                     r_idx, n_idx;
    logic [2*COORD_W-1:0]     r_mem [MAX_SITES];
    logic [2*COORD_W-1:0]     r_rd_data;
    logic signed [COORD_W-1:0] r_qx, r_qy;
    logic [SQ_W-1:0]          r_sq_x, r_sq_y;
    logic                     r_answered, r_found, r_full;
    t_out_idx                 r_best_idx;
    t_dist                    r_best_dist;

    logic                     w_accept, w_append_ok, w_out_free, w_better;
    logic signed [DIFF_W-1:0] w_dx, w_dy, w_op;
    logic signed [2*DIFF_W-1:0] w_prod;
    logic [SQ_W-1:0]          w_sq;
    t_dist                    w_dist;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_append_ok = (i_command == CMD_APPEND) && (r_count < t_cnt'(MAX_SITES));
    assign w_out_free  = !o_out_valid || i_out_ready;

    // Shared squarer: x difference in S_SQX, y difference otherwise.
    assign w_dx   = $signed({r_rd_data[2*COORD_W-1], r_rd_data[2*COORD_W-1:COORD_W]})
                  - $signed({r_qx[COORD_W-1], r_qx});
    assign w_dy   = $signed({r_rd_data[COORD_W-1], r_rd_data[COORD_W-1:0]})
                  - $signed({r_qy[COORD_W-1], r_qy});
    assign w_op   = (r_state == S_SQX) ? w_dx : w_dy;
    assign w_prod = w_op * w_op;
    assign w_sq   = w_prod[SQ_W-1:0];
    assign w_dist = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign w_better = !r_found || (w_dist < r_best_dist);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DONE;
                    n_idx   = '0;
                    if (i_command == CMD_CLEAR) begin
                        n_count = '0;
                    end else if (w_append_ok) begin
                        n_count = r_count + t_cnt'(1);
                    end else if (i_command == CMD_QUERY && r_count != '0) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:  n_state = S_SQX;
            S_SQX: n_state = S_SQY;
            S_SQY: begin
                n_state = S_CMP;
                n_idx   = r_idx + t_cnt'(1);
            end
            S_CMP: n_state = (r_idx == r_count) ? S_DONE : S_SQX;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (r_state == S_DONE && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Site memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_append_ok) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_coord_x, i_coord_y};
        end
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

    // Working result and datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_qx        <= i_coord_x;
            r_qy        <= i_coord_y;
            r_answered  <= (i_command == CMD_QUERY);
            r_found     <= 1'b0;
            r_full      <= (i_command == CMD_APPEND) && !w_append_ok;
            r_best_idx  <= w_append_ok ? to_out_idx(r_count) : '0;
            r_best_dist <= '0;
        end
        if (r_state == S_SQX) begin
            r_sq_x <= w_sq;
        end
        if (r_state == S_SQY) begin
            r_sq_y <= w_sq;
        end
        if (r_state == S_CMP && w_better) begin
            r_found     <= 1'b1;
            r_best_dist <= w_dist;
            r_best_idx  <= to_out_idx(r_idx - t_cnt'(1));
        end
        if (r_state == S_DONE && w_out_free) begin
            o_answered         <= r_answered;
            o_found            <= r_found;
            o_nearest_index    <= r_best_idx;
            o_nearest_distance <= r_best_dist;
            o_table_full       <= r_full;
        end
    end

endmodule

@@ rtl/core/nss_checker.sv @@
// Port-level checks for nearest_site_search, attached by bind.
// Depends on nss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nss_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input nss_pkg::t_cmd        i_command,
    input logic signed [15:0]   i_coord_x,
    input logic signed [15:0]   i_coord_y,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_answered,
    input logic                 o_found,
    input nss_pkg::t_out_idx    o_nearest_index,
    input nss_pkg::t_dist       o_nearest_distance,
    input logic                 o_table_full
);
    import nss_pkg::*;

    logic w_in_take;
    assign w_in_take = i_in_valid && o_in_ready;

    `NSS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `NSS_ASSERT(a_busy_after_take, i_clk, i_rst_n, w_in_take |=> !o_in_ready)
    `NSS_ASSERT_IMP(a_query_not_full, i_clk, i_rst_n, o_out_valid && (o_answered || o_found), o_answered && !o_table_full)
    `NSS_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_out_valid && o_answered && !o_found, o_nearest_index == '0 && o_nearest_distance == '0)

endmodule

bind nearest_site_search nss_checker u_nss_checker (.*);
